// ===== rtl/d3qmg_pkg.sv =====
// ----------------------------------------------------------------------------
// d3qmg_pkg
// Shared types, constants and the D3Q19 direction table for the mixed
// difference gradient stencil.
// ----------------------------------------------------------------------------
package d3qmg_pkg;

  localparam int unsigned NODE_COUNT = 65536;
  localparam int unsigned ADDR_W     = $clog2(NODE_COUNT);
  localparam int unsigned NODE_W     = 16;
  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned GRAD_W     = 41;
  localparam int unsigned EXTENT_W   = 13;
  localparam int unsigned PLANE_W    = 2 * EXTENT_W;
  // signed width of a neighbour address: node + 2*(plane + nx + 1)
  localparam int unsigned SPAN_W     = 30;
  localparam int unsigned CFG_IDX_W  = 8;

  // centre sample, then 18 first and 18 second neighbours
  localparam int unsigned NUM_DIRS   = 18;
  localparam int unsigned NUM_STEPS  = 2 * NUM_DIRS + 1;
  localparam int unsigned STEP_W     = $clog2(NUM_STEPS);
  localparam int unsigned DIR_W      = $clog2(NUM_DIRS);
  localparam int unsigned NUM_AXES   = 6;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);
  localparam logic signed [SPAN_W-1:0] NODE_LIMIT = SPAN_W'(NODE_COUNT);

  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_COMPUTE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_PER_PLANE = CFG_IDX_W'(1);
  localparam logic [EXTENT_W-1:0]  EXTENT_RESET       = EXTENT_W'(16);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_WAIT
  } state_t;

  // weight class of one fetched sample
  typedef enum logic [2:0] {
    CLS_CENTRE,
    CLS_AXIS1,
    CLS_DIAG1,
    CLS_AXIS2,
    CLS_DIAG2
  } cls_t;

  typedef struct packed {
    logic              valid;
    logic              last;
    logic              in_range;
    cls_t              cls;
    logic [ADDR_W-1:0] idx;
  } step_req_t;

  typedef struct packed {
    logic signed [1:0] dx;
    logic signed [1:0] dy;
    logic signed [1:0] dz;
  } dir_t;

  function automatic dir_t dir_lookup(input logic [DIR_W-1:0] q);
    dir_t d;
    d = '{dx: 2'sd0, dy: 2'sd0, dz: 2'sd0};
    case (q)
      5'd0:  d = '{dx:  2'sd1, dy:  2'sd0, dz:  2'sd0};
      5'd1:  d = '{dx: -2'sd1, dy:  2'sd0, dz:  2'sd0};
      5'd2:  d = '{dx:  2'sd0, dy:  2'sd1, dz:  2'sd0};
      5'd3:  d = '{dx:  2'sd0, dy: -2'sd1, dz:  2'sd0};
      5'd4:  d = '{dx:  2'sd0, dy:  2'sd0, dz:  2'sd1};
      5'd5:  d = '{dx:  2'sd0, dy:  2'sd0, dz: -2'sd1};
      5'd6:  d = '{dx:  2'sd1, dy:  2'sd1, dz:  2'sd0};
      5'd7:  d = '{dx: -2'sd1, dy: -2'sd1, dz:  2'sd0};
      5'd8:  d = '{dx:  2'sd1, dy: -2'sd1, dz:  2'sd0};
      5'd9:  d = '{dx: -2'sd1, dy:  2'sd1, dz:  2'sd0};
      5'd10: d = '{dx:  2'sd1, dy:  2'sd0, dz:  2'sd1};
      5'd11: d = '{dx: -2'sd1, dy:  2'sd0, dz: -2'sd1};
      5'd12: d = '{dx:  2'sd1, dy:  2'sd0, dz: -2'sd1};
      5'd13: d = '{dx: -2'sd1, dy:  2'sd0, dz:  2'sd1};
      5'd14: d = '{dx:  2'sd0, dy:  2'sd1, dz:  2'sd1};
      5'd15: d = '{dx:  2'sd0, dy: -2'sd1, dz: -2'sd1};
      5'd16: d = '{dx:  2'sd0, dy:  2'sd1, dz: -2'sd1};
      5'd17: d = '{dx:  2'sd0, dy: -2'sd1, dz:  2'sd1};
      default: d = '{dx: 2'sd0, dy: 2'sd0, dz: 2'sd0};
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/d3qmg_addr_gen.sv =====
// ----------------------------------------------------------------------------
// d3qmg_addr_gen
// Turns a step number into a registered store address, a range flag and the
// weight class of the sample fetched at that step.
// ----------------------------------------------------------------------------
module d3qmg_addr_gen (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                issue,
  input  logic [d3qmg_pkg::STEP_W-1:0]        step,
  input  logic [d3qmg_pkg::NODE_W-1:0]        node,
  input  logic [d3qmg_pkg::EXTENT_W-1:0]      row_length,
  input  logic [d3qmg_pkg::PLANE_W-1:0]       plane,
  output d3qmg_pkg::step_req_t                req
);

  logic [d3qmg_pkg::DIR_W-1:0]         q;
  logic                                second;
  logic                                centre;
  d3qmg_pkg::dir_t                     dir;
  logic signed [d3qmg_pkg::SPAN_W-1:0] plane_s;
  logic signed [d3qmg_pkg::SPAN_W-1:0] nx_s;
  logic signed [d3qmg_pkg::SPAN_W-1:0] term_x;
  logic signed [d3qmg_pkg::SPAN_W-1:0] term_y;
  logic signed [d3qmg_pkg::SPAN_W-1:0] term_z;
  logic signed [d3qmg_pkg::SPAN_W-1:0] off;
  logic signed [d3qmg_pkg::SPAN_W-1:0] addr;
  d3qmg_pkg::cls_t                     cls;
  logic                                axis;

  always_comb begin
    centre = (step == '0);
    second = (step > d3qmg_pkg::STEP_W'(d3qmg_pkg::NUM_DIRS));
    if (second) begin
      q = d3qmg_pkg::DIR_W'(step - d3qmg_pkg::STEP_W'(d3qmg_pkg::NUM_DIRS + 1));
    end else begin
      q = d3qmg_pkg::DIR_W'(step - d3qmg_pkg::STEP_W'(1));
    end
    dir     = d3qmg_pkg::dir_lookup(q);
    plane_s = $signed(d3qmg_pkg::SPAN_W'(plane));
    nx_s    = $signed(d3qmg_pkg::SPAN_W'(row_length));

    case (dir.dz)
      2'sd1:   term_z = plane_s;
      -2'sd1:  term_z = -plane_s;
      default: term_z = '0;
    endcase
    case (dir.dy)
      2'sd1:   term_y = nx_s;
      -2'sd1:  term_y = -nx_s;
      default: term_y = '0;
    endcase
    term_x = d3qmg_pkg::SPAN_W'(dir.dx);

    off = term_z + term_y + term_x;
    if (centre) begin
      addr = $signed(d3qmg_pkg::SPAN_W'(node));
    end else if (second) begin
      addr = $signed(d3qmg_pkg::SPAN_W'(node)) + (off <<< 1);
    end else begin
      addr = $signed(d3qmg_pkg::SPAN_W'(node)) + off;
    end

    axis = (q < d3qmg_pkg::DIR_W'(d3qmg_pkg::NUM_AXES));
    if (centre) begin
      cls = d3qmg_pkg::CLS_CENTRE;
    end else if (second) begin
      cls = axis ? d3qmg_pkg::CLS_AXIS2 : d3qmg_pkg::CLS_DIAG2;
    end else begin
      cls = axis ? d3qmg_pkg::CLS_AXIS1 : d3qmg_pkg::CLS_DIAG1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      req.valid <= issue;
    end
    req.last     <= (step == d3qmg_pkg::LAST_STEP);
    req.in_range <= (addr >= 0) && (addr < d3qmg_pkg::NODE_LIMIT);
    req.cls      <= cls;
    req.idx      <= addr[d3qmg_pkg::ADDR_W-1:0];
  end

endmodule

// ===== rtl/d3q19_mixed_gradient_stencil.sv =====
// ----------------------------------------------------------------------------
// d3q19_mixed_gradient_stencil
// Phase sample store with a D3Q19 mixed difference gradient engine.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  --------  ----------------------  ------------------------------------
//  command   start / busy            mode, node, phase_value
//  config    cfg_valid / cfg_ready   cfg_index, cfg_data
//  result    result_valid (strobe)   result_node, gradient, out_of_range
//
//  A load is written on acceptance and leaves busy low.
//  A compute holds busy through 37 reads of the single store read port
//  (centre, 18 first and 18 second neighbours) and while they pass the
//  address and read registers; the result strobe comes as busy drops.
//  Synchronous reset sets row_length and rows_per_plane to 16; the store
//  holds no reset value. Results cannot be stalled.
// ----------------------------------------------------------------------------
module d3q19_mixed_gradient_stencil (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   mode,
  input  logic [d3qmg_pkg::NODE_W-1:0]           node,
  input  logic signed [d3qmg_pkg::SAMPLE_W-1:0]  phase_value,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [d3qmg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [d3qmg_pkg::EXTENT_W-1:0]         cfg_data,
  output logic                                   result_valid,
  output logic [d3qmg_pkg::NODE_W-1:0]           result_node,
  output logic signed [d3qmg_pkg::GRAD_W-1:0]    gradient,
  output logic                                   out_of_range
);

  d3qmg_pkg::state_t                     state;
  d3qmg_pkg::state_t                     state_next;
  logic                                  accept;
  logic                                  issue;
  logic [d3qmg_pkg::STEP_W-1:0]          step;
  logic [d3qmg_pkg::NODE_W-1:0]          node_q;
  logic [d3qmg_pkg::EXTENT_W-1:0]        row_length;
  logic [d3qmg_pkg::EXTENT_W-1:0]        rows_per_plane;
  logic [d3qmg_pkg::PLANE_W-1:0]         plane;
  d3qmg_pkg::step_req_t                  req;
  d3qmg_pkg::step_req_t                  rd_req;
  logic [d3qmg_pkg::SAMPLE_W-1:0]        rdata;
  logic [d3qmg_pkg::SAMPLE_W-1:0]        mem [d3qmg_pkg::NODE_COUNT];
  logic signed [d3qmg_pkg::GRAD_W-1:0]   acc;
  logic signed [d3qmg_pkg::GRAD_W-1:0]   acc_next;
  logic signed [d3qmg_pkg::GRAD_W-1:0]   sx;
  logic signed [d3qmg_pkg::GRAD_W-1:0]   contrib;
  logic                                  bad;
  logic                                  bad_next;
  logic                                  load_ok;

  assign busy      = (state != d3qmg_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign load_ok   = (32'(node) < d3qmg_pkg::NODE_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= d3qmg_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    issue      = 1'b0;
    case (state)
      d3qmg_pkg::S_IDLE: begin
        if (accept && mode == d3qmg_pkg::MODE_COMPUTE) begin
          state_next = d3qmg_pkg::S_RUN;
        end
      end
      d3qmg_pkg::S_RUN: begin
        issue = 1'b1;
        if (step == d3qmg_pkg::LAST_STEP) begin
          state_next = d3qmg_pkg::S_WAIT;
        end
      end
      d3qmg_pkg::S_WAIT: begin
        if (rd_req.valid && rd_req.last) begin
          state_next = d3qmg_pkg::S_IDLE;
        end
      end
      default: state_next = d3qmg_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (issue) begin
      step <= (step == d3qmg_pkg::LAST_STEP) ? '0 : step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length     <= d3qmg_pkg::EXTENT_RESET;
      rows_per_plane <= d3qmg_pkg::EXTENT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        d3qmg_pkg::REG_ROW_LENGTH:     row_length     <= cfg_data;
        d3qmg_pkg::REG_ROWS_PER_PLANE: rows_per_plane <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      node_q <= node;
      plane  <= row_length * rows_per_plane;
    end
  end

  d3qmg_addr_gen u_addr_gen (
    .clk        (clk),
    .rst        (rst),
    .issue      (issue),
    .step       (step),
    .node       (node_q),
    .row_length (row_length),
    .plane      (plane),
    .req        (req)
  );

  // sample store: one write port for loads, one registered read port
  always_ff @(posedge clk) begin
    if (accept && mode == d3qmg_pkg::MODE_LOAD && load_ok) begin
      mem[d3qmg_pkg::ADDR_W'(node)] <= phase_value;
    end
    rdata <= mem[req.idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_req.valid <= 1'b0;
    end else begin
      rd_req.valid <= req.valid;
    end
    rd_req.last     <= req.last;
    rd_req.in_range <= req.in_range;
    rd_req.cls      <= req.cls;
    rd_req.idx      <= req.idx;
  end

  // opposite directions pair up, so the vm terms fold into the vp terms:
  // grad = sum 4*w*vp - sum w*vp2 - 72*v, with w = 2 on axes, 1 on diagonals
  always_comb begin
    sx = d3qmg_pkg::GRAD_W'($signed(rdata));
    case (rd_req.cls)
      d3qmg_pkg::CLS_CENTRE: contrib = -((sx <<< 6) + (sx <<< 3));
      d3qmg_pkg::CLS_AXIS1:  contrib = sx <<< 3;
      d3qmg_pkg::CLS_DIAG1:  contrib = sx <<< 2;
      d3qmg_pkg::CLS_AXIS2:  contrib = -(sx <<< 1);
      d3qmg_pkg::CLS_DIAG2:  contrib = -sx;
      default:               contrib = '0;
    endcase
    acc_next = acc + contrib;
    bad_next = bad || !rd_req.in_range;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      acc <= '0;
      bad <= 1'b0;
    end else if (rd_req.valid) begin
      acc <= acc_next;
      bad <= bad_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= rd_req.valid && rd_req.last;
    end
    if (rd_req.valid && rd_req.last) begin
      result_node  <= node_q;
      gradient     <= bad_next ? '0 : acc_next;
      out_of_range <= bad_next;
    end
  end

`ifndef SYNTHESIS
  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe lasted more than one cycle");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && out_of_range) |-> (gradient == '0))
    else $error("out of range result carries a non-zero gradient");

  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && mode == d3qmg_pkg::MODE_COMPUTE) |=> busy)
    else $error("compute transaction did not raise busy");

  a_last_result: assert property (@(posedge clk) disable iff (rst)
    (rd_req.valid && rd_req.last) |=> (result_valid && !busy))
    else $error("final read did not produce a result");

  a_no_read_idle: assert property (@(posedge clk) disable iff (rst)
    (state == d3qmg_pkg::S_IDLE) |-> !req.valid)
    else $error("address request issued while idle");
`endif

endmodule

// ===== test/tb_d3q19_mixed_gradient_stencil.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_d3q19_mixed_gradient_stencil
// Self-checking bench for the D3Q19 mixed difference gradient stencil. Loads
// phase samples, fires gradient computes under several grid extents, and
// compares every result strobe with a table value or a local model of the
// stencil sum. Every address a compute can reach is loaded before it is issued.
// ----------------------------------------------------------------------------
module tb_d3q19_mixed_gradient_stencil;
  import d3qmg_pkg::*;

  localparam int SETTLE_CYCLES  = 45;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 550;
  localparam int WIN            = 48;
  localparam int DIRECTED_ROWS  = 38;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(255);

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [GRAD_W-1:0] gradient;
    logic              oor;
  } grad_result_t;

  typedef enum logic [2:0] {
    ACT_LOAD,
    ACT_COMPUTE,
    ACT_FILL,
    ACT_RING,
    ACT_CFG
  } stim_act_t;

  typedef struct packed {
    stim_act_t             act;
    logic [CFG_IDX_W-1:0]  idx;
    logic [EXTENT_W-1:0]   data;
    logic [NODE_W-1:0]     node;
    logic [SAMPLE_W-1:0]   value;
    logic                  chk;
    logic [GRAD_W-1:0]     grad;
    logic                  oor;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic                 mode;
  logic [NODE_W-1:0]    node;
  logic [SAMPLE_W-1:0]  phase_value;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [EXTENT_W-1:0]  cfg_data;
  logic                 result_valid;
  logic [NODE_W-1:0]    result_node;
  logic [GRAD_W-1:0]    gradient;
  logic                 out_of_range;

  // local copy of the store and of the extents
  logic [SAMPLE_W-1:0] phase_model [NODE_COUNT];
  bit                  written [NODE_COUNT];
  logic [EXTENT_W-1:0] ext_x = EXTENT_RESET;
  logic [EXTENT_W-1:0] ext_y = EXTENT_RESET;

  grad_result_t grad_expect_q [$];
  int           fail_count = 0;
  int           cmd_count = 0;
  int           idle_cycles;
  bit           burst_mode = 1'b0;

  int dir_x [NUM_DIRS] = '{1, -1, 0, 0, 0, 0, 1, -1, 1, -1, 1, -1, 1, -1, 0, 0, 0, 0};
  int dir_y [NUM_DIRS] = '{0, 0, 1, -1, 0, 0, 1, -1, -1, 1, 0, 0, 0, 0, 1, -1, 1, -1};
  int dir_z [NUM_DIRS] = '{0, 0, 0, 0, 1, -1, 0, 0, 0, 0, 1, -1, -1, 1, 1, -1, -1, 1};

  // uniform fields give zero, anything that leaves the store gives zero and the flag
  stim_row_t directed_tab [DIRECTED_ROWS] = '{
    '{ACT_FILL,    8'd0, 13'd0, 16'd1000,  32'h0100_0000, 1'b0, 41'd0, 1'b0},
    '{ACT_COMPUTE, 8'd0, 13'd0, 16'd1000,  32'h0,         1'b1, 41'd0, 1'b0},
    '{ACT_FILL,    8'd0, 13'd0, 16'd2000,  32'h7FFF_FFFF, 1'b0, 41'd0, 1'b0},
    '{ACT_COMPUTE, 8'd0, 13'd0, 16'd2000,  32'h0,         1'b1, 41'd0, 1'b0},
    '{ACT_FILL,    8'd0, 13'd0, 16'd3000,  32'h8000_0000, 1'b0, 41'd0, 1'b0},
    '{ACT_COMPUTE, 8'd0, 13'd0, 16'd3000,  32'h0,         1'b1, 41'd0, 1'b0},
    '{ACT_RING,    8'd0, 13'd0, 16'd3000,  32'h7FFF_FFFF, 1'b0, 41'd0, 1'b0},
    '{ACT_COMPUTE, 8'd0, 13'd0, 16'd3000,  32'h0,         1'b0, 41'd0, 1'b0},
    '{ACT_FILL,    8'd0, 13'd0, 16'd4000,  32'h7FFF_FFFF, 1'b0, 41'd0, 1'b0},
    '{ACT_RING,    8'd0, 13'd0, 16'd4000,  32'h8000_0000, 1'b0, 41'd0, 1'b0},
    '{ACT_COMPUTE, 8'd0, 13'd0, 16'd4000,  32'h0,         1'b0, 41'd0, 1'b0},
    '{ACT_FILL,    8'd0, 13'd0, 16'd544,   32'h0000_0001, 1'b0, 41'd0, 1'b0},
    '{ACT_COMPUTE, 8'd0, 13'd0, 16'd544,   32'h0,         1'b1, 41'd0, 1'b0},
    '{ACT_COMPUTE, 8'd0, 13'd0, 16'd543,   32'h0,         1'b1, 41'd0, 1'b1},
    '{ACT_FILL,    8'd0, 13'd0, 16'd64991, 32'h1234_5678, 1'b0, 41'd0, 1'b0},
    '{ACT_COMPUTE, 8'd0, 13'd0, 16'd64991, 32'h0,         1'b1, 41'd0, 1'b0},
    '{ACT_COMPUTE, 8'd0, 13'd0, 16'd64992, 32'h0,         1'b1, 41'd0, 1'b1},
    '{ACT_COMPUTE, 8'd0, 13'd0, 16'd0,     32'h0,         1'b1, 41'd0, 1'b1},
    '{ACT_COMPUTE, 8'd0, 13'd0, 16'd65535, 32'h0,         1'b1, 41'd0, 1'b1},
    '{ACT_LOAD,    8'd0, 13'd0, 16'd1000,  32'hFFFF_FFFF, 1'b0, 41'd0, 1'b0},
    '{ACT_COMPUTE, 8'd0, 13'd0, 16'd1000,  32'h0,         1'b0, 41'd0, 1'b0},
    '{ACT_CFG, REG_ROW_LENGTH,     13'd1,    16'd0, 32'h0, 1'b0, 41'd0, 1'b0},
    '{ACT_CFG, REG_ROWS_PER_PLANE, 13'd1,    16'd0, 32'h0, 1'b0, 41'd0, 1'b0},
    '{ACT_COMPUTE, 8'd0, 13'd0, 16'd1000,  32'h0,         1'b0, 41'd0, 1'b0},
    '{ACT_CFG, REG_ROW_LENGTH,     13'd0,    16'd0, 32'h0, 1'b0, 41'd0, 1'b0},
    '{ACT_CFG, REG_ROWS_PER_PLANE, 13'd0,    16'd0, 32'h0, 1'b0, 41'd0, 1'b0},
    '{ACT_COMPUTE, 8'd0, 13'd0, 16'd1000,  32'h0,         1'b0, 41'd0, 1'b0},
    '{ACT_CFG, REG_ROW_LENGTH,     13'd4096, 16'd0, 32'h0, 1'b0, 41'd0, 1'b0},
    '{ACT_CFG, REG_ROWS_PER_PLANE, 13'd4096, 16'd0, 32'h0, 1'b0, 41'd0, 1'b0},
    '{ACT_COMPUTE, 8'd0, 13'd0, 16'd30000, 32'h0,         1'b1, 41'd0, 1'b1},
    '{ACT_CFG, REG_ROW_LENGTH,     13'd8191, 16'd0, 32'h0, 1'b0, 41'd0, 1'b0},
    '{ACT_CFG, REG_ROWS_PER_PLANE, 13'd8191, 16'd0, 32'h0, 1'b0, 41'd0, 1'b0},
    '{ACT_COMPUTE, 8'd0, 13'd0, 16'd65535, 32'h0,         1'b1, 41'd0, 1'b1},
    '{ACT_CFG, REG_ROW_LENGTH,     13'd16,   16'd0, 32'h0, 1'b0, 41'd0, 1'b0},
    '{ACT_CFG, REG_ROWS_PER_PLANE, 13'd16,   16'd0, 32'h0, 1'b0, 41'd0, 1'b0},
    '{ACT_CFG, REG_SPARE_LO,       13'd5,    16'd0, 32'h0, 1'b0, 41'd0, 1'b0},
    '{ACT_CFG, REG_SPARE_HI,       13'h1FFF, 16'd0, 32'h0, 1'b0, 41'd0, 1'b0},
    '{ACT_COMPUTE, 8'd0, 13'd0, 16'd4000,  32'h0,         1'b0, 41'd0, 1'b0}
  };

  d3q19_mixed_gradient_stencil u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .node         (node),
    .phase_value  (phase_value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_node  (result_node),
    .gradient     (gradient),
    .out_of_range (out_of_range)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint dir_stride(input int q);
    longint plane;
    plane = longint'(ext_x) * longint'(ext_y);
    return dir_z[q] * plane + dir_y[q] * longint'(ext_x) + dir_x[q];
  endfunction

  function automatic bit fetch_sample(input longint addr, output longint val);
    if (addr < 0 || addr >= longint'(NODE_COUNT)) begin
      val = 0;
      return 1'b0;
    end
    val = longint'($signed(phase_model[addr]));
    return 1'b1;
  endfunction

  function automatic grad_result_t predict_gradient(input logic [NODE_W-1:0] n);
    grad_result_t r;
    longint base, off, vc, vp, vp2, vm, s, acc;
    bit ok;
    base = longint'(n);
    acc = 0;
    ok = fetch_sample(base, vc);
    for (int q = 0; q < int'(NUM_DIRS); q++) begin
      off = dir_stride(q);
      if (!fetch_sample(base + off, vp)) ok = 1'b0;
      if (!fetch_sample(base + 2 * off, vp2)) ok = 1'b0;
      if (!fetch_sample(base - off, vm)) ok = 1'b0;
      s = 5 * vp - vp2 - 3 * vc - vm;
      // axis weight is twice the diagonal one
      acc += (q < int'(NUM_AXES)) ? 2 * s : s;
    end
    r.node     = n;
    r.gradient = ok ? acc[GRAD_W-1:0] : '0;
    r.oor      = !ok;
    return r;
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(int'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000);
      default: return $urandom();
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 20);
    return $urandom_range(21, 70);
  endfunction

  // one command transaction; start stays high when the next one follows at once
  task automatic issue(input logic m, input logic [NODE_W-1:0] n,
                       input logic [SAMPLE_W-1:0] v, input bit chk,
                       input grad_result_t typed);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    mode        <= m;
    node        <= n;
    phase_value <= v;
    do @(posedge clk); while (busy);
    cmd_count++;
    if (m == MODE_LOAD) begin
      phase_model[n] = v;
      written[n]     = 1'b1;
    end else if (chk) begin
      grad_expect_q.push_back(typed);
    end else begin
      grad_expect_q.push_back(predict_gradient(n));
    end
  endtask

  task automatic load_at(input longint a, input bit overwrite, input logic [SAMPLE_W-1:0] v);
    if (a >= 0 && a < longint'(NODE_COUNT)) begin
      if (overwrite || !written[a])
        issue(MODE_LOAD, a[NODE_W-1:0], overwrite ? v : rand_sample(), 1'b0, '0);
    end
  endtask

  // loads the stencil footprint of a node: whole footprint or first ring only
  task automatic load_stencil(input logic [NODE_W-1:0] n, input bit ring_only,
                              input bit overwrite, input logic [SAMPLE_W-1:0] v);
    longint base, off;
    base = longint'(n);
    if (!ring_only) load_at(base, overwrite, v);
    for (int q = 0; q < int'(NUM_DIRS); q++) begin
      off = dir_stride(q);
      load_at(base + off, overwrite, v);
      if (!ring_only) begin
        load_at(base + 2 * off, overwrite, v);
        load_at(base - off, overwrite, v);
      end
    end
  endtask

  task automatic compute_at(input logic [NODE_W-1:0] n, input bit chk, input grad_result_t typed);
    load_stencil(n, 1'b0, 1'b0, '0);
    issue(MODE_COMPUTE, n, rand_sample(), chk, typed);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (grad_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [EXTENT_W-1:0] val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_ROW_LENGTH) ext_x = val;
    else if (idx == REG_ROWS_PER_PLANE) ext_y = val;
  endtask

  task automatic check_result();
    grad_result_t e;
    if (grad_expect_q.size() == 0) begin
      $error("result_node: no result expected, actual %0d", result_node);
      fail_count++;
      return;
    end
    e = grad_expect_q.pop_front();
    if (result_node !== e.node) begin
      $error("result_node: expected %0d, actual %0d", e.node, result_node);
      fail_count++;
    end
    if (gradient !== e.gradient) begin
      $error("gradient: expected %0h, actual %0h", e.gradient, gradient);
      fail_count++;
    end
    if (out_of_range !== e.oor) begin
      $error("out_of_range: expected %0b, actual %0b", e.oor, out_of_range);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((start && !busy) || (cfg_valid && cfg_ready) || result_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (result_valid) check_result();
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("** d3q19_mixed_gradient_stencil: FAILED **");
        $finish;
      end
    end
  end

  initial begin : stimulus
    stim_row_t           row;
    grad_result_t        typed;
    int                  r, rand_start, phase_start, phase_len;
    int unsigned         centre;
    longint              c;
    logic [NODE_W-1:0]   n;
    logic [EXTENT_W-1:0] nx, ny;

    rst         <= 1'b1;
    start       <= 1'b0;
    mode        <= MODE_LOAD;
    node        <= '0;
    phase_value <= '0;
    cfg_valid   <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row   = directed_tab[i];
      typed = '{node: row.node, gradient: row.grad, oor: row.oor};
      case (row.act)
        ACT_LOAD:    issue(MODE_LOAD, row.node, row.value, 1'b0, '0);
        ACT_COMPUTE: compute_at(row.node, row.chk, typed);
        ACT_FILL:    load_stencil(row.node, 1'b0, 1'b1, row.value);
        ACT_RING:    load_stencil(row.node, 1'b1, 1'b1, row.value);
        ACT_CFG:     write_reg(row.idx, row.data);
        default: ;
      endcase
    end

    rand_start = cmd_count;
    while (cmd_count - rand_start < RANDOM_ITEMS) begin
      // mostly small grids, now and then the register extremes
      case ($urandom_range(0, 9))
        0: begin
          nx = 13'd16;
          ny = 13'd16;
        end
        1, 2, 3: begin
          nx = 13'($urandom_range(1, 32));
          ny = 13'($urandom_range(1, 32));
        end
        4, 5: begin
          nx = 13'($urandom_range(1, 8));
          ny = 13'($urandom_range(1, 8));
        end
        6: begin
          nx = 13'($urandom_range(0, 1));
          ny = 13'($urandom_range(0, 1));
        end
        7: begin
          nx = 13'($urandom_range(1, 4096));
          ny = 13'($urandom_range(1, 64));
        end
        8: begin
          nx = 13'($urandom_range(0, 8191));
          ny = 13'($urandom_range(0, 8191));
        end
        default: begin
          nx = $urandom_range(0, 1) ? 13'd4096 : 13'd8191;
          ny = 13'($urandom_range(1, 4096));
        end
      endcase
      write_reg(REG_ROW_LENGTH, nx);
      write_reg(REG_ROWS_PER_PLANE, ny);
      if ($urandom_range(0, 7) == 0) write_reg(REG_SPARE_LO, 13'($urandom()));

      case ($urandom_range(0, 9))
        0: centre = $urandom_range(0, 600);
        1: centre = $urandom_range(64900, 65535);
        default: centre = $urandom_range(0, 65535);
      endcase
      burst_mode  = ($urandom_range(0, 3) == 0);
      phase_len   = $urandom_range(40, 100);
      phase_start = cmd_count;

      while (cmd_count - phase_start < phase_len) begin
        c = longint'(centre) + longint'($urandom_range(0, 2 * WIN)) - WIN;
        if (c < 0) c = 0;
        if (c > 65535) c = 65535;
        n = c[NODE_W-1:0];
        r = $urandom_range(0, 99);
        if (r < 50) begin
          compute_at(n, 1'b0, '0);
        end else if (r < 85) begin
          issue(MODE_LOAD, n, rand_sample(), 1'b0, '0);
        end else if (r < 95) begin
          issue(MODE_LOAD, 16'($urandom()), rand_sample(), 1'b0, '0);
        end else begin
          case ($urandom_range(0, 2))
            0: n = '0;
            1: n = '1;
            default: n = 16'($urandom());
          endcase
          compute_at(n, 1'b0, '0);
        end
      end
    end

    burst_mode = 1'b0;
    settle();
    if (fail_count == 0) begin
      $display("** d3q19_mixed_gradient_stencil: PASSED **");
    end else begin
      $display("** d3q19_mixed_gradient_stencil: FAILED **");
    end
    $finish;
  end

endmodule
